// ===== rtl/core/lru_pr_pkg.sv =====
// Shared constants and controller/datapath command and status types for the LRU replacer.
`timescale 1ns / 1ps

package lru_pr_pkg;

	localparam int FRAMES_DEF    = 16;
	localparam int PAGE_BITS_DEF = 16;

	// Fixed field widths of the ports
	localparam int CFG_W       = 5;
	localparam int PAGE_PORT_W = 16;
	localparam int FRAME_OUT_W = 4;
	localparam int COUNT_W     = 32;

	localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

	// Controller -> datapath
	typedef struct packed {
		logic capture;   // latch the page of an accepted transaction
		logic lookup;    // tag compare, then hit update, fill, or start of the stamp scan
		logic scan;      // stamp scan step
		logic commit;    // replace the oldest frame
	} cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic replace;   // lookup found neither a hit nor an empty active frame
		logic scan_last; // last active stamp is being compared this cycle
	} stat_t;

endpackage

// ===== rtl/core/lru_pr_ctrl.sv =====
// Controller state machine for the LRU replacer.
`timescale 1ns / 1ps

module lru_pr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  lru_pr_pkg::stat_t  stat,
	output lru_pr_pkg::cmd_t   cmd
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_LOOKUP = 4'b0010,
		S_SCAN   = 4'b0100,
		S_COMMIT = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_d = S_LOOKUP;
			end
			S_LOOKUP: begin
				state_d = stat.replace ? S_SCAN : S_IDLE;
			end
			S_SCAN: begin
				if (stat.scan_last) state_d = S_COMMIT;
			end
			S_COMMIT: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign cmd.capture = (state_q == S_IDLE) && start;
	assign cmd.lookup  = (state_q == S_LOOKUP);
	assign cmd.scan    = (state_q == S_SCAN);
	assign cmd.commit  = (state_q == S_COMMIT);

endmodule

// ===== rtl/core/lru_pr_dpath.sv =====
// Datapath of the LRU replacer: frame tags, stamp memory, scan, totals and result registers.
`timescale 1ns / 1ps

module lru_pr_dpath #(
	parameter int FRAMES    = lru_pr_pkg::FRAMES_DEF,
	parameter int PAGE_BITS = lru_pr_pkg::PAGE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  lru_pr_pkg::cmd_t                     cmd,
	output lru_pr_pkg::stat_t                    stat,
	input  logic                                 cfg_we,
	input  logic [lru_pr_pkg::CFG_W-1:0]         cfg_wdata,
	input  logic [lru_pr_pkg::PAGE_PORT_W-1:0]   page_number,
	output logic                                 done,
	output logic                                 hit,
	output logic [lru_pr_pkg::FRAME_OUT_W-1:0]   frame_index,
	output logic                                 evicted_valid,
	output logic [lru_pr_pkg::PAGE_PORT_W-1:0]   evicted_page,
	output logic [lru_pr_pkg::COUNT_W-1:0]       fault_count,
	output logic [lru_pr_pkg::COUNT_W-1:0]       hit_count
);

	localparam int PW    = (PAGE_BITS < lru_pr_pkg::PAGE_PORT_W) ? PAGE_BITS
	                                                              : lru_pr_pkg::PAGE_PORT_W;
	localparam int IW    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CNT_W = $clog2(FRAMES + 1);
	localparam int CW    = (CNT_W > lru_pr_pkg::CFG_W) ? CNT_W : lru_pr_pkg::CFG_W;
	localparam int SW    = lru_pr_pkg::COUNT_W;

	// Configuration and control state
	logic [lru_pr_pkg::CFG_W-1:0] cfg_q;
	logic [CNT_W-1:0]             filled_q;
	logic [SW-1:0]                ref_q;
	logic [SW-1:0]                fault_q;
	logic [SW-1:0]                hits_q;
	logic [CNT_W-1:0]             issue_q;
	logic                         rd_valid_q;
	logic [IW-1:0]                rd_idx_q;
	logic                         done_q;

	// Payload state
	logic [PW-1:0]  page_q;
	logic [PW-1:0]  frame_page_q [FRAMES];
	logic [SW-1:0]  stamp_mem    [FRAMES];
	logic [SW-1:0]  rd_data_q;
	logic [SW-1:0]  best_q;
	logic [IW-1:0]  best_idx_q;
	logic           hit_res_q;
	logic [IW-1:0]  frame_res_q;
	logic           ev_valid_q;
	logic [PW-1:0]  ev_page_q;

	// Combinational
	logic [CW-1:0]    cfg_ext;
	logic [CW-1:0]    act_ext;
	logic [CNT_W-1:0] act_c;
	logic [CNT_W-1:0] search_c;
	logic [FRAMES-1:0] match_c;
	logic             hit_c;
	logic [IW-1:0]    hit_idx_c;
	logic             fill_c;
	logic             direct_c;
	logic             mem_we;
	logic [IW-1:0]    mem_waddr;
	logic             mem_re;
	logic [IW-1:0]    mem_raddr;
	logic             issue_more;
	logic             take_c;

	// Clamp the active frame count to 1..FRAMES
	always_comb begin
		cfg_ext = CW'(cfg_q);
		if (cfg_ext == '0) begin
			act_ext = CW'(1);
		end else if (cfg_ext > CW'(FRAMES)) begin
			act_ext = CW'(FRAMES);
		end else begin
			act_ext = cfg_ext;
		end
		act_c    = CNT_W'(act_ext);
		search_c = (filled_q < act_c) ? filled_q : act_c;
		fill_c   = (filled_q < act_c);
	end

	// Tag compare in every frame lane, lowest matching frame wins
	always_comb begin
		hit_idx_c = '0;
		for (int j = 0; j < FRAMES; j++) begin
			match_c[j] = (CNT_W'(j) < search_c) && (frame_page_q[j] == page_q);
		end
		for (int j = FRAMES - 1; j >= 0; j--) begin
			if (match_c[j]) hit_idx_c = IW'(j);
		end
		hit_c = |match_c;
	end

	assign direct_c   = hit_c || fill_c;
	assign issue_more = (issue_q < act_c);

	assign stat.replace   = !direct_c;
	assign stat.scan_last = rd_valid_q && (CNT_W'(rd_idx_q) == (act_c - CNT_W'(1)));

	// Strict less-than keeps the lowest index on ties
	assign take_c = (rd_idx_q == '0) || (rd_data_q < best_q);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		if (cmd.lookup) begin
			if (hit_c) begin
				mem_we    = 1'b1;
				mem_waddr = hit_idx_c;
			end else if (fill_c) begin
				mem_we    = 1'b1;
				mem_waddr = filled_q[IW-1:0];
			end else begin
				mem_re    = 1'b1;
			end
		end else if (cmd.scan) begin
			mem_re    = issue_more;
			mem_raddr = issue_q[IW-1:0];
		end else if (cmd.commit) begin
			mem_we    = 1'b1;
			mem_waddr = best_idx_q;
		end
	end

	// Stamp memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) stamp_mem[mem_waddr] <= ref_q;
		if (mem_re) rd_data_q <= stamp_mem[mem_raddr];
	end

	// Frame tags and payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) page_q <= page_number[PW-1:0];
		if (cmd.lookup && !hit_c && fill_c) frame_page_q[filled_q[IW-1:0]] <= page_q;
		if (cmd.commit) frame_page_q[best_idx_q] <= page_q;
		if (cmd.scan && rd_valid_q && take_c) begin
			best_q     <= rd_data_q;
			best_idx_q <= rd_idx_q;
		end
		if (cmd.lookup && direct_c) begin
			hit_res_q   <= hit_c;
			frame_res_q <= hit_c ? hit_idx_c : filled_q[IW-1:0];
			ev_valid_q  <= 1'b0;
			ev_page_q   <= '0;
		end
		if (cmd.commit) begin
			hit_res_q   <= 1'b0;
			frame_res_q <= best_idx_q;
			ev_valid_q  <= 1'b1;
			ev_page_q   <= frame_page_q[best_idx_q];
		end
	end

	// Control state, totals and the result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q      <= lru_pr_pkg::CFG_RESET;
			filled_q   <= '0;
			ref_q      <= '0;
			fault_q    <= '0;
			hits_q     <= '0;
			issue_q    <= '0;
			rd_valid_q <= 1'b0;
			rd_idx_q   <= '0;
			done_q     <= 1'b0;
		end else begin
			if (cfg_we) cfg_q <= cfg_wdata;
			done_q     <= (cmd.lookup && direct_c) || cmd.commit;
			rd_valid_q <= mem_re;
			if (mem_re) rd_idx_q <= mem_raddr;
			if (cmd.lookup) begin
				issue_q <= CNT_W'(1);
				if (direct_c) ref_q <= ref_q + SW'(1);
				if (hit_c) begin
					if (hits_q != '1) hits_q <= hits_q + SW'(1);
				end else if (fill_c) begin
					filled_q <= filled_q + CNT_W'(1);
					if (fault_q != '1) fault_q <= fault_q + SW'(1);
				end
			end
			if (cmd.scan && issue_more) issue_q <= issue_q + CNT_W'(1);
			if (cmd.commit) begin
				ref_q <= ref_q + SW'(1);
				if (fault_q != '1) fault_q <= fault_q + SW'(1);
			end
		end
	end

	assign done          = done_q;
	assign hit           = hit_res_q;
	assign frame_index   = lru_pr_pkg::FRAME_OUT_W'(frame_res_q);
	assign evicted_valid = ev_valid_q;
	assign evicted_page  = lru_pr_pkg::PAGE_PORT_W'(ev_page_q);
	assign fault_count   = fault_q;
	assign hit_count     = hits_q;

endmodule

// ===== rtl/core/lru_page_replacement.sv =====
// Top level of the fully associative LRU page replacer: controller plus datapath.
`timescale 1ns / 1ps

// Channel    Ports                                      Transfer
// ---------  -----------------------------------------  -------------------------------
// request    start, busy, page_number                   edge with start high, busy low
// result     done, hit, frame_index, evicted_valid,     edge that ends the cycle of the
//            evicted_page, fault_count, hit_count       one-cycle done strobe
// config     cfg_we, cfg_wdata (frames_in_use)          edge with cfg_we high
//
// A hit or a fill of an empty frame goes from acceptance through the lookup state to the
// done strobe; a replacement adds the stamp scan, which reads one frame stamp per cycle
// from the single-read-port stamp memory, and then the commit state.
// Reset: arst_n clears the fill count, stamp counter, totals and the controller; frame
// tags and stamps are not cleared, since only filled frames are ever read.
// Stalls: the receiver cannot stall; busy drops in the same cycle that done is shown,
// so a new transaction can be taken at the edge that delivers the result.

module lru_page_replacement #(
	parameter int FRAMES    = lru_pr_pkg::FRAMES_DEF,
	parameter int PAGE_BITS = lru_pr_pkg::PAGE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [lru_pr_pkg::PAGE_PORT_W-1:0]   page_number,
	input  logic                                 cfg_we,
	input  logic [lru_pr_pkg::CFG_W-1:0]         cfg_wdata,
	output logic                                 done,
	output logic                                 hit,
	output logic [lru_pr_pkg::FRAME_OUT_W-1:0]   frame_index,
	output logic                                 evicted_valid,
	output logic [lru_pr_pkg::PAGE_PORT_W-1:0]   evicted_page,
	output logic [lru_pr_pkg::COUNT_W-1:0]       fault_count,
	output logic [lru_pr_pkg::COUNT_W-1:0]       hit_count
);

	// Command and status between the controller and the datapath
	lru_pr_pkg::cmd_t  cmd;
	lru_pr_pkg::stat_t stat;

	// Sequence the transaction: lookup, then for a replacement the stamp scan and commit
	lru_pr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	// Hold the frames, search them and register the result
	lru_pr_dpath #(
		.FRAMES    (FRAMES),
		.PAGE_BITS (PAGE_BITS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.page_number   (page_number),
		.done          (done),
		.hit           (hit),
		.frame_index   (frame_index),
		.evicted_valid (evicted_valid),
		.evicted_page  (evicted_page),
		.fault_count   (fault_count),
		.hit_count     (hit_count)
	);

	// An accepted transaction always occupies the block for the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	// A result only follows work in progress
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a transaction in flight");

	// Busy only drops when the result is delivered
	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	// The end of the stamp scan always leads to the replacement
	a_scan_commit: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan && stat.scan_last) |=> cmd.commit)
		else $error("stamp scan finished without a replacement");

	// A hit never reports an eviction
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(hit && evicted_valid))
		else $error("hit reported together with an eviction");

endmodule
